>>> rtl/core/stcd_pkg.sv
// Shared types, codes and helpers for the sprite texel color decoder.
`default_nettype none

package stcd_pkg;

    localparam int LOOKUP_ENTRIES = 16;
    localparam int LUT_AW         = 4;

    localparam logic [2:0] CFG_COLOR_MODE      = 3'd0;
    localparam logic [2:0] CFG_COLOR_BANK      = 3'd1;
    localparam logic [2:0] CFG_PALETTE_MASK    = 3'd2;
    localparam logic [2:0] CFG_ZERO_DOT_OPAQUE = 3'd3;
    localparam logic [2:0] CFG_END_CODE_ENABLE = 3'd4;

    localparam logic [3:0]  END_CODE_NIBBLE = 4'hF;
    localparam logic [15:0] END_CODE_DIRECT = 16'h7FFF;

    typedef enum logic [1:0] {
        MODE_TABLE4   = 2'd0,
        MODE_BANK4    = 2'd1,
        MODE_BANK8    = 2'd2,
        MODE_DIRECT16 = 2'd3
    } t_color_mode;

    typedef enum logic [1:0] {
        REQ_PAL_WR = 2'd0,
        REQ_LUT_WR = 2'd1,
        REQ_SOURCE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_DOTS   = 2'd1,
        OP_PAL_WR = 2'd2,
        OP_LUT_WR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_DIRECT = 2'd0,
        K_LUT    = 2'd1,
        K_PAL    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] table_index;
        logic [15:0] table_word;
        logic [15:0] source_word;
        logic [2:0]  valid_dots;
        logic        final_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        pixel_drawn;
        logic        last_of_word;
        logic        last_of_texture;
    } t_out_item;

    typedef struct packed {
        t_color_mode color_mode;
        logic [15:0] color_bank;
        logic [7:0]  palette_mask;
        logic        zero_dot_opaque;
        logic        end_code_enable;
    } t_cfg;

    // What one lane found for its dot.
    typedef struct packed {
        logic              visible;
        t_kind             kind;
        logic [LUT_AW-1:0] lut_addr;
        logic [15:0]       pal_idx;
        logic [15:0]       direct_word;
    } t_lane_res;

    // One slot of the issue pipeline: a dot or a table write.
    typedef struct packed {
        t_op         op;
        t_lane_res   lane;
        logic [15:0] addr;
        logic [15:0] data;
        logic        last_w;
        logic        last_t;
    } t_slot;

    function automatic logic [31:0] rgb555_to_color(input logic [15:0] w);
        return {8'hFF, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stcd_lane.sv
// One decode lane: classifies a single dot of a source word.
`default_nettype none

module stcd_lane (
    input  wire stcd_pkg::t_cfg      i_cfg,
    input  wire [3:0]                i_nibble,
    input  wire [7:0]                i_byte,
    input  wire [15:0]               i_word,
    output stcd_pkg::t_lane_res      o_res
);
    import stcd_pkg::*;

    logic [7:0] masked;

    assign masked = i_byte & i_cfg.palette_mask;

    always_comb begin
        o_res.visible     = 1'b0;
        o_res.kind        = K_DIRECT;
        o_res.lut_addr    = i_nibble;
        o_res.pal_idx     = 16'h0000;
        o_res.direct_word = i_word;
        unique case (i_cfg.color_mode)
            MODE_TABLE4: begin
                o_res.kind    = K_LUT;
                o_res.visible = !((i_cfg.end_code_enable && i_nibble == END_CODE_NIBBLE) ||
                                  (i_nibble == 4'h0 && !i_cfg.zero_dot_opaque));
            end
            MODE_BANK4: begin
                o_res.kind    = K_PAL;
                o_res.pal_idx = {12'h000, i_nibble} | i_cfg.color_bank;
                o_res.visible = !((i_cfg.end_code_enable && i_nibble == END_CODE_NIBBLE) ||
                                  (i_nibble == 4'h0 && !i_cfg.zero_dot_opaque));
            end
            MODE_BANK8: begin
                o_res.kind    = K_PAL;
                o_res.pal_idx = {8'h00, masked} | i_cfg.color_bank;
                o_res.visible = !((i_cfg.end_code_enable && masked == i_cfg.palette_mask) ||
                                  (i_byte == 8'h00 && !i_cfg.zero_dot_opaque));
            end
            MODE_DIRECT16: begin
                o_res.kind    = K_DIRECT;
                o_res.visible = !((i_cfg.end_code_enable && i_word == END_CODE_DIRECT) ||
                                  !i_word[15]);
            end
            default: begin
                o_res.visible = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/stcd_merge.sv
// Merge stage: serial lookup-table and palette reads, color forming, output register.
`default_nettype none

module stcd_merge #(
    parameter int PALETTE_WORDS = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_issue_valid,
    input  wire stcd_pkg::t_slot     i_issue,
    output logic                     o_adv,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output stcd_pkg::t_out_item      o_out_data
);
    import stcd_pkg::*;

    localparam int PAL_AW = (PALETTE_WORDS > 1) ? $clog2(PALETTE_WORDS) : 1;

    logic [15:0] r_lut_mem [LOOKUP_ENTRIES];
    logic [15:0] r_pal_mem [PALETTE_WORDS];

    logic        r_s1_valid;
    t_slot       r_s1_slot;
    logic [15:0] r_lut_q;

    logic        r_s2_valid;
    logic        r_s2_visible;
    logic        r_s2_direct;
    logic [15:0] r_s2_word;
    logic        r_s2_last_w;
    logic        r_s2_last_t;
    logic [15:0] r_pal_q;

    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        s1_direct;
    logic [15:0] s1_idx;
    logic [15:0] s1_word;
    logic        s1_in_range;
    logic        s1_visible;
    logic [15:0] s2_color_word;

    // Whole pipeline moves together whenever the output register can take a new transaction.
    assign o_adv       = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Lookup table: write and read at issue time keeps program order.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            if (i_issue_valid && i_issue.op == OP_LUT_WR) begin
                r_lut_mem[i_issue.addr[LUT_AW-1:0]] <= i_issue.data;
            end
            r_lut_q <= r_lut_mem[i_issue.lane.lut_addr];
        end
    end

    always_comb begin
        s1_direct = 1'b0;
        s1_idx    = r_s1_slot.lane.pal_idx;
        s1_word   = r_s1_slot.lane.direct_word;
        unique case (r_s1_slot.lane.kind)
            K_DIRECT: s1_direct = 1'b1;
            K_LUT: begin
                if (r_lut_q[15]) begin
                    s1_direct = 1'b1;
                    s1_word   = r_lut_q;
                end else begin
                    s1_idx = {5'b00000, r_lut_q[10:0]};
                end
            end
            K_PAL: s1_direct = 1'b0;
            default: s1_direct = 1'b0;
        endcase
        s1_in_range = ({1'b0, s1_idx} < 17'(PALETTE_WORDS));
        s1_visible  = r_s1_slot.lane.visible && (s1_direct || s1_in_range);
    end

    // Palette: write and read one stage later, still in order.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            if (r_s1_valid && r_s1_slot.op == OP_PAL_WR) begin
                r_pal_mem[r_s1_slot.addr[PAL_AW-1:0]] <= r_s1_slot.data;
            end
            r_pal_q <= r_pal_mem[s1_idx[PAL_AW-1:0]];
        end
    end

    assign s2_color_word = r_s2_direct ? r_s2_word : r_pal_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_s1_valid  <= i_issue_valid;
            r_s2_valid  <= r_s1_valid && (r_s1_slot.op == OP_DOTS);
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s1_slot    <= i_issue;
            r_s2_visible <= s1_visible;
            r_s2_direct  <= s1_direct;
            r_s2_word    <= s1_word;
            r_s2_last_w  <= r_s1_slot.last_w;
            r_s2_last_t  <= r_s1_slot.last_t;
            r_out_data.pixel_color     <= r_s2_visible ? rgb555_to_color(s2_color_word)
                                                       : 32'h0000_0000;
            r_out_data.pixel_drawn     <= r_s2_visible;
            r_out_data.last_of_word    <= r_s2_last_w;
            r_out_data.last_of_texture <= r_s2_last_t;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sprite_texel_color_decoder.sv
// Top level: configuration registers, decode lanes, word register and issue sequencer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//   cfg     | input     | i_cfg_wr_en              | i_cfg_index, i_cfg_wdata
//
// Four lanes decode all dots of a source word in the accept cycle; the issue
// sequencer then sends one dot per cycle while the output does not stall, and a
// table write as a single slot. The single palette read port sets that rate.
// An issued dot passes through the s1, s2 and output registers.
// Reset is synchronous, active low; tables keep their contents and hold garbage until written.
// An output stall freezes the issue pipeline; only an empty word register still takes a word.
`default_nettype none

module sprite_texel_color_decoder #(
    parameter int PALETTE_WORDS = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire stcd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output stcd_pkg::t_out_item      o_out_data,
    input  wire                      i_cfg_wr_en,
    input  wire [2:0]                i_cfg_index,
    input  wire [15:0]               i_cfg_wdata
);
    import stcd_pkg::*;

    t_cfg        r_cfg;
    t_lane_res   lane_res [4];

    logic        r_w_valid;
    t_op         r_w_op;
    t_lane_res   r_w_lanes [4];
    logic [1:0]  r_w_k;
    logic [1:0]  r_w_last;
    logic [15:0] r_w_addr;
    logic [15:0] r_w_data;
    logic        r_w_final;

    logic        accept;
    logic        adv;
    logic        last_issue;
    t_op         in_op;
    logic [2:0]  per_word;
    logic [2:0]  n_dots;
    t_slot       issue;
    logic        issue_last_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode      <= MODE_TABLE4;
            r_cfg.color_bank      <= 16'h0000;
            r_cfg.palette_mask    <= 8'hFF;
            r_cfg.zero_dot_opaque <= 1'b0;
            r_cfg.end_code_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COLOR_MODE:      r_cfg.color_mode      <= t_color_mode'(i_cfg_wdata[1:0]);
                CFG_COLOR_BANK:      r_cfg.color_bank      <= i_cfg_wdata;
                CFG_PALETTE_MASK:    r_cfg.palette_mask    <= i_cfg_wdata[7:0];
                CFG_ZERO_DOT_OPAQUE: r_cfg.zero_dot_opaque <= i_cfg_wdata[0];
                CFG_END_CODE_ENABLE: r_cfg.end_code_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        stcd_lane u_lane (
            .i_cfg    (r_cfg),
            .i_nibble (i_in_data.source_word[15-4*g -: 4]),
            .i_byte   (i_in_data.source_word[15-8*(g%2) -: 8]),
            .i_word   (i_in_data.source_word),
            .o_res    (lane_res[g])
        );
    end

    always_comb begin
        unique case (r_cfg.color_mode)
            MODE_TABLE4, MODE_BANK4: per_word = 3'd4;
            MODE_BANK8:              per_word = 3'd2;
            MODE_DIRECT16:           per_word = 3'd1;
            default:                 per_word = 3'd1;
        endcase
        n_dots = (i_in_data.valid_dots == 3'd0) ? 3'd1 : i_in_data.valid_dots;
        if (n_dots > per_word) begin
            n_dots = per_word;
        end

        in_op = OP_NOP;
        priority if (i_in_data.req_type == REQ_PAL_WR) begin
            if ({6'b000000, i_in_data.table_index} < 17'(PALETTE_WORDS)) begin
                in_op = OP_PAL_WR;
            end
        end else if (i_in_data.req_type == REQ_LUT_WR) begin
            if (i_in_data.table_index < 11'(LOOKUP_ENTRIES)) begin
                in_op = OP_LUT_WR;
            end
        end else if (i_in_data.req_type == REQ_SOURCE) begin
            in_op = OP_DOTS;
        end else begin
            in_op = OP_NOP;
        end
    end

    assign last_issue = (r_w_k == r_w_last);
    assign o_in_stall = r_w_valid && !(adv && last_issue);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_w_k     <= 2'd0;
        end else if (accept) begin
            // drop items that write nothing and give no result
            r_w_valid <= (in_op != OP_NOP);
            r_w_k     <= 2'd0;
        end else if (r_w_valid && adv) begin
            if (last_issue) begin
                r_w_valid <= 1'b0;
            end else begin
                r_w_k <= r_w_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w_op    <= in_op;
            r_w_lanes <= lane_res;
            r_w_last  <= (in_op == OP_DOTS) ? 2'(n_dots - 3'd1) : 2'd0;
            r_w_addr  <= {5'b00000, i_in_data.table_index};
            r_w_data  <= i_in_data.table_word;
            r_w_final <= i_in_data.final_word;
        end
    end

    assign issue_last_w = last_issue;

    always_comb begin
        issue.op     = r_w_op;
        issue.lane   = r_w_lanes[r_w_k];
        issue.addr   = r_w_addr;
        issue.data   = r_w_data;
        issue.last_w = issue_last_w;
        issue.last_t = issue_last_w && r_w_final;
    end

    stcd_merge #(
        .PALETTE_WORDS (PALETTE_WORDS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_valid (r_w_valid),
        .i_issue       (issue),
        .o_adv         (adv),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire
